// ===== rtl/biweight_probe_set_signal_top_assert.svh =====
// assertion macros used by the port checker
`ifndef BIWEIGHT_PROBE_SET_SIGNAL_TOP_ASSERT_SVH
`define BIWEIGHT_PROBE_SET_SIGNAL_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BWPS_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed: same-cycle rule");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BWPS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed: next-cycle rule");

`endif

// ===== rtl/bwps_pkg.sv =====
// shared constants, datapath op codes and controller/datapath bundles
package bwps_pkg;

  localparam int MAX_PROBES = 32;
  localparam int IDX_W      = $clog2(MAX_PROBES);
  localparam int CNT_W      = $clog2(MAX_PROBES + 1);

  localparam int INT_W  = 24;
  localparam int LOG_W  = 22;
  localparam int OLOG_W = 21;
  localparam int USED_W = 6;
  localparam int P_W    = 5;
  localparam int FRAC_W = 16;
  localparam int MANT_W = 32;
  localparam int W_W    = 17;
  localparam int DEN_W  = 25;
  localparam int DIV_W  = W_W + LOG_W + CNT_W;
  localparam int STEP_W = $clog2(DIV_W + 1);
  localparam int SQ_W   = 63;
  localparam int SQ_STEPS = (SQ_W + 1) / 2;
  localparam int T_W    = 33;

  localparam logic [LOG_W-1:0] LOG_LOW  = 22'd1572864;
  localparam logic [DEN_W-1:0] EPS_Q16  = 25'd7;
  localparam logic [W_W-1:0]   ONE_Q16  = 17'd65536;
  localparam logic [INT_W-1:0] INT_MAX  = 24'hFFFFFF;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_LOG_MUL, OP_LOG_NORM, OP_LOG_WR, OP_SET_INIT, OP_RD_I,
    OP_PRE_USE, OP_DECIDE, OP_RANK_INIT, OP_GET_I, OP_RD_J, OP_CMP_J, OP_RANK_FIN,
    OP_RANK_DONE, OP_W_INIT, OP_W_CHK, OP_DIV_STEP, OP_MUL_UU, OP_OM, OP_MUL_OO,
    OP_MUL_WX, OP_W_ACC, OP_FIN_INIT, OP_FIN_DONE, OP_AL_INIT, OP_AL_PREP,
    OP_SQ_STEP, OP_SQ_DONE, OP_AL_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last_probe;
    logic i_last;
    logic j_last;
    logic log_last;
    logic div_last;
    logic sq_last;
    logic al_last;
    logic rd_used;
    logic trivial;
    logic phase;
    logic w_take;
    logic al_skip;
  } stat_t;

endpackage

// ===== rtl/bwps_ctrl.sv =====
// sequencing state machine for the probe-set signal block
module bwps_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  bwps_pkg::stat_t stat,
  output bwps_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_strobe
);
  import bwps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOG_MUL, S_LOG_NORM, S_LOG_WR, S_SET_INIT, S_PRE_RD, S_PRE_USE,
    S_DECIDE, S_RANK_INIT, S_R_RDI, S_R_GETI, S_R_RDJ, S_R_CMPJ, S_R_FIN,
    S_R_DONE, S_W_INIT, S_W_RD, S_W_CHK, S_W_DIV, S_W_U2, S_W_OM, S_W_W,
    S_W_WX, S_W_ACC, S_FIN_INIT, S_F_DIV, S_F_DONE, S_AL_INIT, S_AL_PREP,
    S_SQ_STEP, S_SQ_DONE, S_AL_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   strobe_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (start) state_nxt = S_LOG_MUL;
      S_LOG_MUL:   state_nxt = S_LOG_NORM;
      S_LOG_NORM:  state_nxt = stat.log_last ? S_LOG_WR : S_LOG_MUL;
      S_LOG_WR:    state_nxt = stat.last_probe ? S_SET_INIT : S_IDLE;
      S_SET_INIT:  state_nxt = S_PRE_RD;
      S_PRE_RD:    state_nxt = S_PRE_USE;
      S_PRE_USE:   state_nxt = stat.i_last ? S_DECIDE : S_PRE_RD;
      S_DECIDE:    state_nxt = stat.trivial ? S_AL_INIT : S_RANK_INIT;
      S_RANK_INIT: state_nxt = S_R_RDI;
      S_R_RDI:     state_nxt = S_R_GETI;
      S_R_GETI: begin
        if (stat.rd_used) state_nxt = S_R_RDJ;
        else state_nxt = stat.i_last ? S_R_DONE : S_R_RDI;
      end
      S_R_RDJ:     state_nxt = S_R_CMPJ;
      S_R_CMPJ:    state_nxt = stat.j_last ? S_R_FIN : S_R_RDJ;
      S_R_FIN:     state_nxt = stat.i_last ? S_R_DONE : S_R_RDI;
      S_R_DONE:    state_nxt = stat.phase ? S_W_INIT : S_R_RDI;
      S_W_INIT:    state_nxt = S_W_RD;
      S_W_RD:      state_nxt = S_W_CHK;
      S_W_CHK: begin
        if (stat.w_take) state_nxt = S_W_DIV;
        else state_nxt = stat.i_last ? S_FIN_INIT : S_W_RD;
      end
      S_W_DIV:     state_nxt = stat.div_last ? S_W_U2 : S_W_DIV;
      S_W_U2:      state_nxt = S_W_OM;
      S_W_OM:      state_nxt = S_W_W;
      S_W_W:       state_nxt = S_W_WX;
      S_W_WX:      state_nxt = S_W_ACC;
      S_W_ACC:     state_nxt = stat.i_last ? S_FIN_INIT : S_W_RD;
      S_FIN_INIT:  state_nxt = S_F_DIV;
      S_F_DIV:     state_nxt = stat.div_last ? S_F_DONE : S_F_DIV;
      S_F_DONE:    state_nxt = S_AL_INIT;
      S_AL_INIT:   state_nxt = stat.al_skip ? S_AL_OUT : S_AL_PREP;
      S_AL_PREP:   state_nxt = S_SQ_STEP;
      S_SQ_STEP:   state_nxt = stat.sq_last ? S_SQ_DONE : S_SQ_STEP;
      S_SQ_DONE:   state_nxt = stat.al_last ? S_AL_OUT : S_AL_PREP;
      S_AL_OUT:    state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE:      cmd.op = start ? OP_LOAD : OP_NONE;
      S_LOG_MUL:   cmd.op = OP_LOG_MUL;
      S_LOG_NORM:  cmd.op = OP_LOG_NORM;
      S_LOG_WR:    cmd.op = OP_LOG_WR;
      S_SET_INIT:  cmd.op = OP_SET_INIT;
      S_PRE_RD:    cmd.op = OP_RD_I;
      S_PRE_USE:   cmd.op = OP_PRE_USE;
      S_DECIDE:    cmd.op = OP_DECIDE;
      S_RANK_INIT: cmd.op = OP_RANK_INIT;
      S_R_RDI:     cmd.op = OP_RD_I;
      S_R_GETI:    cmd.op = OP_GET_I;
      S_R_RDJ:     cmd.op = OP_RD_J;
      S_R_CMPJ:    cmd.op = OP_CMP_J;
      S_R_FIN:     cmd.op = OP_RANK_FIN;
      S_R_DONE:    cmd.op = OP_RANK_DONE;
      S_W_INIT:    cmd.op = OP_W_INIT;
      S_W_RD:      cmd.op = OP_RD_I;
      S_W_CHK:     cmd.op = OP_W_CHK;
      S_W_DIV:     cmd.op = OP_DIV_STEP;
      S_W_U2:      cmd.op = OP_MUL_UU;
      S_W_OM:      cmd.op = OP_OM;
      S_W_W:       cmd.op = OP_MUL_OO;
      S_W_WX:      cmd.op = OP_MUL_WX;
      S_W_ACC:     cmd.op = OP_W_ACC;
      S_FIN_INIT:  cmd.op = OP_FIN_INIT;
      S_F_DIV:     cmd.op = OP_DIV_STEP;
      S_F_DONE:    cmd.op = OP_FIN_DONE;
      S_AL_INIT:   cmd.op = OP_AL_INIT;
      S_AL_PREP:   cmd.op = OP_AL_PREP;
      S_SQ_STEP:   cmd.op = OP_SQ_STEP;
      S_SQ_DONE:   cmd.op = OP_SQ_DONE;
      S_AL_OUT:    cmd.op = OP_AL_OUT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= (state_nxt != S_IDLE);
      strobe_r <= (state_r == S_AL_OUT);
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;

endmodule

// ===== rtl/bwps_dp.sv =====
// datapath: log2 unit, probe store, rank sweep, divider, multiplier, square root
module bwps_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bwps_pkg::cmd_t                 cmd,
  output bwps_pkg::stat_t                stat,
  input  logic [bwps_pkg::INT_W-1:0]     in_probe_intensity,
  input  logic                           in_probe_masked,
  input  logic                           in_last_probe,
  input  logic                           cfg_we,
  input  logic [bwps_pkg::INT_W-1:0]     cfg_floor_value,
  output logic [bwps_pkg::INT_W-1:0]     out_signal_value,
  output logic signed [bwps_pkg::OLOG_W-1:0] out_signal_log2,
  output logic [bwps_pkg::USED_W-1:0]    out_probes_used,
  output logic                           out_all_were_masked
);
  import bwps_pkg::*;

  function automatic logic [LOG_W-1:0] abs_diff(input logic [LOG_W-1:0] a,
                                               input logic [LOG_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [LOG_W-1:0] mean2(input logic [LOG_W-1:0] a,
                                            input logic [LOG_W-1:0] b);
    logic [LOG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    mean2 = s[LOG_W:1];
  endfunction

  // control registers
  logic [INT_W-1:0] floor_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] unm_r;

  // probe store
  logic [LOG_W:0] mem [MAX_PROBES];
  logic [LOG_W:0] rd_r;
  logic [IDX_W-1:0] rd_addr;

  // payload registers
  logic [MANT_W-1:0] m_r;
  logic [P_W-1:0]    p_r;
  logic [FRAC_W-1:0] frac_r;
  logic [STEP_W-1:0] step_r;
  logic              masked_r;
  logic              last_r;
  logic [2*MANT_W-1:0] mul_r;
  logic [CNT_W-1:0]  i_r, j_r, n_r, rank_r, ka_r, kb_r;
  logic              allm_r;
  logic              phase_r;
  logic [LOG_W-1:0]  first_r, second_r, min_r, max_r;
  logic [LOG_W+CNT_W-1:0] sum_r;
  logic [LOG_W-1:0]  fi_r, a_r, b_r, mid_r, x_r, lb_r;
  logic [DEN_W-1:0]  d_r;
  logic [DIV_W-1:0]  dvd_r, quo_r, num_r;
  logic [DEN_W-1:0]  dvs_r, rem_r;
  logic [W_W-1:0]    om_r;
  logic [LOG_W-1:0]  den_r;
  logic [T_W-1:0]    t_r;
  logic [3:0]        aj_r;
  logic [SQ_W-1:0]   sa_r, sr_r, sbit_r;
  logic [INT_W-1:0]  sigval_r;
  logic [OLOG_W-1:0] siglog_r;
  logic [USED_W-1:0] used_r;
  logic              allm_out_r;

  // combinational
  logic [INT_W-1:0]  fl_v;
  logic [P_W-1:0]    lead_p;
  logic [MANT_W-1:0] m_init;
  logic [MANT_W-1:0] sq_q;
  logic [LOG_W-1:0]  log_c;
  logic [LOG_W-1:0]  rd_x;
  logic              used_c;
  logic [LOG_W-1:0]  f_c, diff_c;
  logic              rank_less;
  logic [DEN_W:0]    remsh;
  logic              div_ge;
  logic [SQ_W:0]     sq_sum;
  logic              sq_ge;
  logic [MANT_W-1:0] mul_a, mul_b;
  logic [W_W-1:0]    u2_c, w_c;
  logic [LOG_W-1:0]  e_c;
  logic [5:0]        k_c, sh_c;
  logic              zero_c, sat_c;
  logic [T_W-1:0]    tt_c;
  logic [T_W+1:0]    rnd_c, v_c;
  logic [INT_W-1:0]  al_val;
  logic [LOG_W-1:0]  spread_c;

  // floor, zero guard and leading-one search
  always_comb begin
    fl_v = (in_probe_intensity < floor_r) ? floor_r : in_probe_intensity;
    if (fl_v == '0) fl_v = INT_W'(1);
    lead_p = '0;
    for (int b = 0; b < INT_W; b++) begin
      if (fl_v[b]) lead_p = P_W'(b);
    end
  end

  assign m_init = MANT_W'(fl_v) << (P_W'(30) - lead_p);
  assign sq_q   = mul_r[61:30];
  assign log_c  = LOG_W'({p_r, frac_r}) + LOG_LOW;

  assign rd_x      = rd_r[LOG_W-1:0];
  assign used_c    = allm_r | ~rd_r[LOG_W];
  assign diff_c    = abs_diff(rd_x, mid_r);
  assign f_c       = phase_r ? diff_c : rd_x;
  assign rank_less = (f_c < fi_r) || ((f_c == fi_r) && (j_r < i_r));
  assign rd_addr   = (cmd.op == OP_RD_J) ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];

  assign remsh  = {rem_r, dvd_r[DIV_W-1]};
  assign div_ge = remsh >= {1'b0, dvs_r};

  assign sq_sum = {1'b0, sr_r} + {1'b0, sbit_r};
  assign sq_ge  = {1'b0, sa_r} >= sq_sum;

  assign u2_c = mul_r[32:16];
  assign w_c  = mul_r[32:16];
  assign spread_c = mean2(a_r, b_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LOG_MUL: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      OP_MUL_UU: begin
        mul_a = MANT_W'(quo_r[W_W-1:0]);
        mul_b = MANT_W'(quo_r[W_W-1:0]);
      end
      OP_MUL_OO: begin
        mul_a = MANT_W'(om_r);
        mul_b = MANT_W'(om_r);
      end
      OP_MUL_WX: begin
        mul_a = MANT_W'(w_c);
        mul_b = MANT_W'(x_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // antilog range split and final rounding shift
  assign zero_c = lb_r < LOG_LOW;
  assign e_c    = lb_r - LOG_LOW;
  assign k_c    = e_c[LOG_W-1:16];
  assign sat_c  = !zero_c && (k_c >= 6'd24);
  assign tt_c   = e_c[aj_r] ? (t_r << 1) : t_r;
  assign sh_c   = 6'd30 - k_c;
  assign rnd_c  = (T_W+2)'(t_r) + ((T_W+2)'(1) << (sh_c - 6'd1));
  assign v_c    = rnd_c >> sh_c;
  assign al_val = (v_c > (T_W+2)'(INT_MAX)) ? INT_MAX : v_c[INT_W-1:0];

  always_comb begin
    stat.last_probe = last_r;
    stat.i_last     = (CNT_W'(i_r + CNT_W'(1)) == cnt_r);
    stat.j_last     = (CNT_W'(j_r + CNT_W'(1)) == cnt_r);
    stat.log_last   = (step_r == STEP_W'(FRAC_W - 1));
    stat.div_last   = (step_r == STEP_W'(DIV_W - 1));
    stat.sq_last    = (step_r == STEP_W'(SQ_STEPS - 1));
    stat.al_last    = (aj_r == 4'd15);
    stat.rd_used    = used_c;
    stat.trivial    = (n_r == CNT_W'(1)) || (n_r == CNT_W'(2)) || (max_r == min_r);
    stat.phase      = phase_r;
    stat.w_take     = used_c && (DEN_W'(diff_c) <= d_r);
    stat.al_skip    = zero_c | sat_c;
  end

  // config and set counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= INT_W'(1);
      cnt_r   <= '0;
      unm_r   <= '0;
    end else begin
      if (cfg_we) floor_r <= cfg_floor_value;
      if (cmd.op == OP_LOG_WR && cnt_r < CNT_W'(MAX_PROBES)) begin
        cnt_r <= CNT_W'(cnt_r + CNT_W'(1));
        if (!masked_r) unm_r <= CNT_W'(unm_r + CNT_W'(1));
      end else if (cmd.op == OP_AL_OUT) begin
        cnt_r <= '0;
        unm_r <= '0;
      end
    end
  end

  // probe store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOG_WR && cnt_r < CNT_W'(MAX_PROBES)) begin
      mem[cnt_r[IDX_W-1:0]] <= {masked_r, log_c};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    mul_r <= (2*MANT_W)'(mul_a) * (2*MANT_W)'(mul_b);
    unique case (cmd.op)
      OP_LOAD: begin
        m_r      <= m_init;
        p_r      <= lead_p;
        frac_r   <= '0;
        step_r   <= '0;
        masked_r <= in_probe_masked;
        last_r   <= in_last_probe;
      end
      OP_LOG_NORM: begin
        if (sq_q[MANT_W-1]) begin
          m_r    <= {1'b0, sq_q[MANT_W-1:1]};
          frac_r <= {frac_r[FRAC_W-2:0], 1'b1};
        end else begin
          m_r    <= sq_q;
          frac_r <= {frac_r[FRAC_W-2:0], 1'b0};
        end
        step_r <= STEP_W'(step_r + STEP_W'(1));
      end
      OP_SET_INIT: begin
        i_r    <= '0;
        n_r    <= '0;
        sum_r  <= '0;
        allm_r <= (unm_r == '0);
      end
      OP_PRE_USE: begin
        if (used_c) begin
          if (n_r == '0) begin
            first_r <= rd_x;
            min_r   <= rd_x;
            max_r   <= rd_x;
          end else begin
            if (rd_x < min_r) min_r <= rd_x;
            if (rd_x > max_r) max_r <= rd_x;
          end
          if (n_r == CNT_W'(1)) second_r <= rd_x;
          sum_r <= sum_r + (LOG_W+CNT_W)'(rd_x);
          n_r   <= CNT_W'(n_r + CNT_W'(1));
        end
        i_r <= CNT_W'(i_r + CNT_W'(1));
      end
      OP_DECIDE: begin
        lb_r <= (n_r == CNT_W'(2)) ? mean2(first_r, second_r) : first_r;
      end
      OP_RANK_INIT: begin
        phase_r <= 1'b0;
        i_r     <= '0;
        ka_r    <= CNT_W'((n_r - CNT_W'(1)) >> 1);
        kb_r    <= CNT_W'(n_r >> 1);
      end
      OP_GET_I: begin
        if (used_c) begin
          fi_r   <= f_c;
          rank_r <= '0;
          j_r    <= '0;
        end else begin
          i_r <= CNT_W'(i_r + CNT_W'(1));
        end
      end
      OP_CMP_J: begin
        if (used_c && rank_less) rank_r <= CNT_W'(rank_r + CNT_W'(1));
        j_r <= CNT_W'(j_r + CNT_W'(1));
      end
      OP_RANK_FIN: begin
        if (rank_r == ka_r) a_r <= fi_r;
        if (rank_r == kb_r) b_r <= fi_r;
        i_r <= CNT_W'(i_r + CNT_W'(1));
      end
      OP_RANK_DONE: begin
        if (!phase_r) begin
          mid_r   <= spread_c;
          phase_r <= 1'b1;
          i_r     <= '0;
        end else begin
          d_r <= DEN_W'({spread_c, 2'b00}) + DEN_W'(spread_c) + EPS_Q16;
        end
      end
      OP_W_INIT: begin
        i_r   <= '0;
        num_r <= '0;
        den_r <= '0;
      end
      OP_W_CHK: begin
        if (stat.w_take) begin
          dvd_r  <= DIV_W'(diff_c) << 16;
          dvs_r  <= d_r;
          rem_r  <= '0;
          quo_r  <= '0;
          step_r <= '0;
          x_r    <= rd_x;
        end else begin
          i_r <= CNT_W'(i_r + CNT_W'(1));
        end
      end
      OP_DIV_STEP: begin
        rem_r  <= div_ge ? DEN_W'(remsh - {1'b0, dvs_r}) : remsh[DEN_W-1:0];
        quo_r  <= {quo_r[DIV_W-2:0], div_ge};
        dvd_r  <= dvd_r << 1;
        step_r <= STEP_W'(step_r + STEP_W'(1));
      end
      OP_OM: begin
        om_r <= ONE_Q16 - u2_c;
      end
      OP_MUL_WX: begin
        den_r <= den_r + LOG_W'(w_c);
      end
      OP_W_ACC: begin
        num_r <= num_r + DIV_W'(mul_r[W_W+LOG_W-1:0]);
        i_r   <= CNT_W'(i_r + CNT_W'(1));
      end
      OP_FIN_INIT: begin
        // no weight survived: fall back to the plain mean
        if (den_r == '0) begin
          dvd_r <= DIV_W'(sum_r) + DIV_W'(n_r >> 1);
          dvs_r <= DEN_W'(n_r);
        end else begin
          dvd_r <= num_r + DIV_W'(den_r >> 1);
          dvs_r <= DEN_W'(den_r);
        end
        rem_r  <= '0;
        quo_r  <= '0;
        step_r <= '0;
      end
      OP_FIN_DONE: begin
        lb_r <= quo_r[LOG_W-1:0];
      end
      OP_AL_INIT: begin
        t_r  <= T_W'(1) << 30;
        aj_r <= '0;
      end
      OP_AL_PREP: begin
        sa_r   <= {tt_c, 30'b0};
        sr_r   <= '0;
        sbit_r <= {1'b1, {(SQ_W-1){1'b0}}};
        step_r <= '0;
      end
      OP_SQ_STEP: begin
        if (sq_ge) begin
          sa_r <= sa_r - sq_sum[SQ_W-1:0];
          sr_r <= (sr_r >> 1) + sbit_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
        step_r <= STEP_W'(step_r + STEP_W'(1));
      end
      OP_SQ_DONE: begin
        t_r  <= sr_r[T_W-1:0];
        aj_r <= aj_r + 4'd1;
      end
      OP_AL_OUT: begin
        sigval_r   <= zero_c ? '0 : (sat_c ? INT_MAX : al_val);
        siglog_r   <= lb_r[OLOG_W-1:0];
        used_r     <= USED_W'(n_r);
        allm_out_r <= allm_r;
      end
      default: ;
    endcase
  end

  assign out_signal_value    = sigval_r;
  assign out_signal_log2     = siglog_r;
  assign out_probes_used     = used_r;
  assign out_all_were_masked = allm_out_r;

endmodule

// ===== rtl/biweight_probe_set_signal_top.sv =====
// top level of the probe-set biweight signal block
//
// one probe per request: start is taken when busy is low. the next probe is
// taken only after this one's intensity is floored and turned into log2
// (sixteen squaring passes through the shared 32x32 multiplier, plus the
// store write). the last probe of a set then runs the estimate with busy
// high: a pre-pass over the stored probes; unless one or two probes are used
// or all used values are equal, two rank sweeps for the median and the
// median absolute deviation, each reading the single read port of the probe
// store, the weighting pass through the 45-step shift-subtract divider for
// each kept probe and one final division; then the antilog (sixteen 32-step
// square roots), skipped when the result is zero or saturates. the result
// is shown for one cycle with out_strobe and cannot be stalled; busy drops
// in that same cycle so the next set may start at once. a new floor may be
// written on cfg at any idle time; the floor in force when a probe is taken
// applies to it.
module biweight_probe_set_signal_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_probe_intensity,
  input  logic        in_probe_masked,
  input  logic        in_last_probe,
  output logic        out_strobe,
  output logic [23:0] out_signal_value,
  output logic signed [20:0] out_signal_log2,
  output logic [5:0]  out_probes_used,
  output logic        out_all_were_masked,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_floor_value
);
  import bwps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // floor register is only sampled on probe load, so writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: owns busy and the result strobe
  bwps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // datapath: probe store, arithmetic units and result registers
  bwps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_probe_intensity  (in_probe_intensity),
    .in_probe_masked     (in_probe_masked),
    .in_last_probe       (in_last_probe),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_floor_value     (cfg_floor_value),
    .out_signal_value    (out_signal_value),
    .out_signal_log2     (out_signal_log2),
    .out_probes_used     (out_probes_used),
    .out_all_were_masked (out_all_were_masked)
  );

endmodule

// ===== rtl/bwps_checker.sv =====
// port-level checker for the probe-set signal block, with its bind
`include "biweight_probe_set_signal_top_assert.svh"

module bwps_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // a result comes out in the cycle the block goes idle
  `BWPS_AST_IMP(a_strobe_not_busy, out_strobe, !busy)
  // the block was working in the cycle before a result
  `BWPS_AST_IMP(a_strobe_after_busy, out_strobe, $past(busy))
  // results never come back to back
  `BWPS_AST_NXT(a_strobe_single, out_strobe, !out_strobe)
  // a taken request always starts work
  `BWPS_AST_NXT(a_accept_busy, start && !busy, busy)

endmodule

bind biweight_probe_set_signal_top bwps_checker u_chk (.*);
